/* rtl/stack_machine_executor_defines.svh */
// Assertion helpers for the executor RTL.
`ifndef STACK_MACHINE_EXECUTOR_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define SME_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sme_pkg.sv */
`default_nettype none
package sme_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  localparam int WORD_W      = 32;
  localparam int OP_W        = 4;
  localparam int DEPTH_W     = 7;
  localparam int ST_W        = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam int DIV_STEPS   = WORD_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  typedef enum logic [OP_W-1:0] {
    OP_CONST = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_MAX   = 4'd5,
    OP_MIN   = 4'd6,
    OP_NEG   = 4'd7,
    OP_DUP   = 4'd8,
    OP_SWAP  = 4'd9
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_RD_A     = 9'b000000010,
    S_RD_B     = 9'b000000100,
    S_EXEC     = 9'b000001000,
    S_DIV      = 9'b000010000,
    S_DIV_SIGN = 9'b000100000,
    S_WR       = 9'b001000000,
    S_WR2      = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

endpackage
`default_nettype wire

/* rtl/stack_machine_executor.sv */
// Stack machine executor.
// Input stream (s_*): one instruction per transfer, opcode and push word.
// Output stream (m_*): one result per instruction: new top of stack, depth
// and status (ok, underflow, overflow, divide by zero; on error the stack
// is untouched).
// The stack lives in a RAM with one write port and a registered read port.
// Each item is handled by a sequencer: read top, read next, execute on the
// ALU or the divider, write, finish. Errors and unknown opcodes skip the
// write; swap writes the RAM twice; div runs one quotient bit per cycle
// over 32 steps plus a sign fixup.
// The input is taken one item at a time; s_tready is high when the
// sequencer is idle, including while a finished result waits on m_tready.
// The next result waits in its last step until the output register frees.
// Reset empties the stack (depth zero) and drops any pending result;
// the RAM itself is not cleared.
`default_nettype none
module stack_machine_executor (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // [3:0] operation, [35:4] push_value
  input  wire logic [sme_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [31:0] top_value, [38:32] stack_depth, [40:39] status
  output logic [sme_pkg::OUT_TDATA_W-1:0]       m_tdata
);
  import sme_pkg::*;

  `include "stack_machine_executor_defines.svh"

  state_t state;

  logic [OP_W-1:0]   op;
  logic [WORD_W-1:0] val;
  logic [SP_W-1:0]   sp;
  logic [SP_W-1:0]   sp_new;
  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] b;
  logic [WORD_W-1:0] r;
  logic [WORD_W-1:0] top;
  status_t           st;
  logic [ADDR_W-1:0] waddr;

  // stack RAM
  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [ADDR_W-1:0] raddr;
  logic [WORD_W-1:0] rdata;
  logic              wen;
  logic [ADDR_W-1:0] wen_addr;
  logic [WORD_W-1:0] wen_data;

  // divider
  logic [WORD_W:0]      rem;
  logic [WORD_W-1:0]    quo;
  logic [WORD_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 qneg;
  logic [WORD_W:0]      shifted;
  logic [WORD_W:0]      diff;

  // output register
  logic [WORD_W-1:0]  out_top;
  logic [DEPTH_W-1:0] out_depth;
  status_t            out_status;

  logic [SP_W-1:0] sp_m1;
  logic [SP_W-1:0] sp_m2;
  logic            need_two;
  logic            need_one;
  logic            known;
  logic            full;
  logic            out_free;
  status_t         exec_st;
  logic [WORD_W-1:0] alu;
  logic [WORD_W-1:0] abs_a;
  logic [WORD_W-1:0] abs_b;

  assign sp_m1 = sp - SP_W'(1);
  assign sp_m2 = sp - SP_W'(2);
  assign full  = (sp >= SP_W'(STACK_DEPTH));
  assign out_free = !m_tvalid || m_tready;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {{(OUT_TDATA_W - WORD_W - DEPTH_W - ST_W){1'b0}},
                     out_status, out_depth, out_top};

  always_comb begin
    raddr = sp_m1[ADDR_W-1:0];
    if (state == S_RD_B) begin
      raddr = sp_m2[ADDR_W-1:0];
    end
  end

  always_comb begin
    wen      = 1'b0;
    wen_addr = waddr;
    wen_data = r;
    if (state == S_WR) begin
      wen = 1'b1;
    end else if (state == S_WR2) begin
      wen      = 1'b1;
      wen_addr = sp_m1[ADDR_W-1:0];
      wen_data = b;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[wen_addr] <= wen_data;
    end
    rdata <= mem[raddr];
  end

  // Operand needs and status, evaluated in the execute step (b is rdata).
  always_comb begin
    need_two = 1'b0;
    need_one = 1'b0;
    known    = 1'b1;
    case (op)
      OP_CONST: ;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAX, OP_MIN, OP_SWAP: need_two = 1'b1;
      OP_NEG, OP_DUP: need_one = 1'b1;
      default: known = 1'b0;
    endcase
  end

  always_comb begin
    exec_st = ST_OK;
    if ((need_two && sp < SP_W'(2)) || (need_one && sp == '0)) begin
      exec_st = ST_UNDER;
    end else if ((op == OP_CONST || op == OP_DUP) && full) begin
      exec_st = ST_OVER;
    end else if (op == OP_DIV && rdata == '0) begin
      exec_st = ST_DIVZ;
    end
  end

  // Shared ALU
  always_comb begin
    case (op)
      OP_CONST: alu = val;
      OP_ADD:   alu = a + rdata;
      OP_SUB:   alu = a - rdata;
      OP_MUL:   alu = a * rdata;
      OP_MAX:   alu = ($signed(a) > $signed(rdata)) ? a : rdata;
      OP_MIN:   alu = ($signed(a) < $signed(rdata)) ? a : rdata;
      OP_NEG:   alu = '0 - a;
      OP_DUP:   alu = a;
      OP_SWAP:  alu = a;
      default:  alu = a;
    endcase
  end

  assign abs_a   = a[WORD_W-1] ? ('0 - a) : a;
  assign abs_b   = rdata[WORD_W-1] ? ('0 - rdata) : rdata;
  assign shifted = {rem[WORD_W-1:0], quo[WORD_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sp       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // the finish step reloads the output register on its own
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tdata[OP_W-1:0];
            val   <= s_tdata[OP_W +: WORD_W];
            state <= S_RD_A;
          end
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          a     <= rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          b  <= rdata;
          st <= exec_st;
          if (exec_st != ST_OK || !known) begin
            top   <= (sp != '0) ? a : '0;
            state <= S_FINISH;
          end else if (op == OP_DIV) begin
            rem   <= '0;
            quo   <= abs_a;
            dvs   <= abs_b;
            qneg  <= a[WORD_W-1] ^ rdata[WORD_W-1];
            cnt   <= '0;
            waddr <= sp_m2[ADDR_W-1:0];
            sp_new <= sp_m1;
            state <= S_DIV;
          end else begin
            r     <= alu;
            state <= S_WR;
            case (op)
              OP_CONST, OP_DUP: begin
                waddr  <= sp[ADDR_W-1:0];
                sp_new <= sp + SP_W'(1);
              end
              OP_NEG: begin
                waddr  <= sp_m1[ADDR_W-1:0];
                sp_new <= sp;
              end
              OP_SWAP: begin
                waddr  <= sp_m2[ADDR_W-1:0];
                sp_new <= sp;
              end
              default: begin
                waddr  <= sp_m2[ADDR_W-1:0];
                sp_new <= sp_m1;
              end
            endcase
          end
        end
        S_DIV: begin
          if (!diff[WORD_W]) begin
            rem <= diff;
            quo <= {quo[WORD_W-2:0], 1'b1};
          end else begin
            rem <= shifted;
            quo <= {quo[WORD_W-2:0], 1'b0};
          end
          cnt <= cnt + DIV_CNT_W'(1);
          if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= S_DIV_SIGN;
          end
        end
        S_DIV_SIGN: begin
          r     <= qneg ? ('0 - quo) : quo;
          state <= S_WR;
        end
        S_WR: begin
          sp  <= sp_new;
          top <= r;
          if (op == OP_SWAP) begin
            state <= S_WR2;
          end else begin
            state <= S_FINISH;
          end
        end
        S_WR2: begin
          top   <= b;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_top    <= top;
            out_depth  <= DEPTH_W'(sp);
            out_status <= st;
            m_tvalid   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SME_ASSERT(a_sp_bound, sp <= SP_W'(STACK_DEPTH), "stack pointer beyond depth")
  `SME_ASSERT_NEXT(a_accept_seq, s_tvalid && s_tready, state == S_RD_A, "accept did not start read")
  `SME_ASSERT(a_sp_only_on_write, (!$past(rst) && sp != $past(sp)) |-> $past(state) == S_WR, "stack pointer moved outside write step")
  `SME_ASSERT(a_out_from_finish, $rose(m_tvalid) |-> $past(state) == S_FINISH, "result shown without finishing an item")

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import sme_pkg::*;

  localparam int MAX_CYCLES    = 1000000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_PRINTS    = 40;
  localparam int RANDOM_ITEMS  = 900;
  localparam int PRESSURE_ITEMS = 40;

  localparam logic [OP_W-1:0]   OP_UNUSED_FIRST = 4'hA;
  localparam logic [OP_W-1:0]   OP_UNUSED_LAST  = 4'hF;
  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

  // receiver stall modes
  localparam int RX_OPEN     = 0;
  localparam int RX_RANDOM   = 1;
  localparam int RX_PERIODIC = 2;
  localparam int RX_HOLD     = 3;

  typedef struct packed {
    logic [WORD_W-1:0]  top;
    logic [DEPTH_W-1:0] depth;
    status_t            status;
  } result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tready = 1'b0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic [OUT_TDATA_W-1:0] m_tdata;

  logic [WORD_W-1:0] stack_words [STACK_DEPTH];
  int                stack_count = 0;
  result_t           pending_results [$];
  int                err_count = 0;
  int                cycle_count = 0;
  int                burst_left = 0;
  int                hold_req = 0;

  int rx_hold_seen = 0;
  int rx_left = 0;
  int rx_kind = RX_OPEN;
  int rx_period = 2;
  int rx_phase = 0;

  always #4 clk = ~clk;

  stack_machine_executor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Stack model: updates on each accepted instruction, queues the result.
  function automatic void predict_step(input logic [OP_W-1:0] op,
                                       input logic [WORD_W-1:0] val);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] r;
    status_t           st;
    result_t           res;
    a  = (stack_count >= 1) ? stack_words[stack_count-1] : '0;
    b  = (stack_count >= 2) ? stack_words[stack_count-2] : '0;
    r  = '0;
    st = ST_OK;
    case (op)
      OP_CONST: begin
        if (stack_count >= STACK_DEPTH) st = ST_OVER;
        else begin
          stack_words[stack_count] = val;
          stack_count++;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAX, OP_MIN, OP_SWAP: begin
        if (stack_count < 2) st = ST_UNDER;
        else if (op == OP_SWAP) begin
          stack_words[stack_count-2] = a;
          stack_words[stack_count-1] = b;
        end else if (op == OP_DIV && b == '0) st = ST_DIVZ;
        else begin
          case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            // most negative / -1 wraps back to itself
            OP_DIV: r = (a == WORD_MIN && b == '1) ? a : WORD_W'($signed(a) / $signed(b));
            OP_MAX: r = ($signed(a) > $signed(b)) ? a : b;
            default: r = ($signed(a) < $signed(b)) ? a : b;
          endcase
          stack_words[stack_count-2] = r;
          stack_count--;
        end
      end
      OP_NEG: begin
        if (stack_count < 1) st = ST_UNDER;
        else stack_words[stack_count-1] = '0 - a;
      end
      OP_DUP: begin
        if (stack_count < 1) st = ST_UNDER;
        else if (stack_count >= STACK_DEPTH) st = ST_OVER;
        else begin
          stack_words[stack_count] = a;
          stack_count++;
        end
      end
      default: ;
    endcase
    res.top    = (stack_count >= 1) ? stack_words[stack_count-1] : '0;
    res.depth  = DEPTH_W'(stack_count);
    res.status = st;
    pending_results.push_back(res);
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h", m_tdata));
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[WORD_W-1:0] !== exp_r.top)
          report_mismatch($sformatf("top_value %h, want %h",
                                    m_tdata[WORD_W-1:0], exp_r.top));
        if (m_tdata[WORD_W +: DEPTH_W] !== exp_r.depth)
          report_mismatch($sformatf("stack_depth %0d, want %0d",
                                    m_tdata[WORD_W +: DEPTH_W], exp_r.depth));
        if (m_tdata[WORD_W+DEPTH_W +: ST_W] !== exp_r.status)
          report_mismatch($sformatf("status %0d, want %s",
                                    m_tdata[WORD_W+DEPTH_W +: ST_W], exp_r.status.name()));
      end
    end
  end

  // Result-side stall pattern; a long hold starts when hold_req changes.
  always @(posedge clk) begin
    if (hold_req != rx_hold_seen) begin
      rx_hold_seen = hold_req;
      rx_left      = LONG_HOLD;
      rx_kind      = RX_HOLD;
    end
    if (rx_left == 0) begin
      rx_kind   = $urandom_range(RX_OPEN, RX_PERIODIC);
      rx_left   = $urandom_range(10, 80);
      rx_period = $urandom_range(2, 5);
    end
    rx_left--;
    rx_phase++;
    case (rx_kind)
      RX_OPEN:     m_tready <= 1'b1;
      RX_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: m_tready <= (rx_phase % rx_period) == 0;
      default:     m_tready <= 1'b0;
    endcase
  end

  task automatic send_instr(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] val);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W-OP_W-WORD_W){1'b0}}, val, op};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    predict_step(op, val);
  endtask

  task automatic wait_results();
    s_tvalid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return '1;
      4, 5:    return WORD_W'($urandom_range(0, 20)) - WORD_W'(10);
      default: return $urandom();
    endcase
  endfunction

  // Steers the stack toward target depth; a few items are pure noise.
  function automatic logic [OP_W-1:0] pick_op(input int target);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return OP_W'($urandom_range(0, 15));
    if (stack_count < target) begin
      case (roll % 4)
        0:       return OP_DUP;
        1:       return OP_NEG;
        default: return OP_CONST;
      endcase
    end
    case (roll % 8)
      6:       return OP_SWAP;
      7:       return OP_NEG;
      default: return OP_W'($urandom_range(OP_ADD, OP_MIN));
    endcase
  endfunction

  task automatic test_directed();
    // every stack op on an empty stack underflows
    for (int i = OP_ADD; i <= OP_SWAP; i++) send_instr(OP_W'(i), rand_word());
    send_instr(OP_UNUSED_LAST, '1);
    send_instr(OP_UNUSED_FIRST, '0);
    send_instr(OP_CONST, WORD_MAX);
    send_instr(OP_DUP, '0);
    send_instr(OP_ADD, '0);          // wraps
    send_instr(OP_SWAP, '1);         // one word: underflow
    send_instr(OP_CONST, '0);
    send_instr(OP_CONST, 32'd7);
    send_instr(OP_DIV, '0);          // divisor is zero
    send_instr(OP_SWAP, '0);
    send_instr(OP_SUB, '0);
    send_instr(OP_CONST, '1);
    send_instr(OP_CONST, WORD_MIN);
    send_instr(OP_DIV, '0);          // most negative / -1
    send_instr(OP_NEG, '0);          // neg of most negative
    send_instr(OP_MUL, '0);
    send_instr(OP_CONST, 32'd5);
    send_instr(OP_DUP, '0);
    send_instr(OP_MAX, '0);          // tie
    send_instr(OP_DUP, '0);
    send_instr(OP_MIN, '0);          // tie
    wait_results();
  endtask

  task automatic test_stack_limits();
    while (stack_count < STACK_DEPTH) send_instr(OP_CONST, rand_word());
    send_instr(OP_CONST, rand_word());
    send_instr(OP_DUP, rand_word());
    send_instr(OP_NEG, rand_word());
    send_instr(OP_SWAP, rand_word());
    while (stack_count > 1) send_instr(OP_W'($urandom_range(OP_ADD, OP_MIN)), rand_word());
    wait_results();
  endtask

  task automatic test_backpressure();
    int target;
    target   = $urandom_range(1, STACK_DEPTH);
    hold_req <= hold_req + 1;
    repeat (PRESSURE_ITEMS) send_instr(pick_op(target), rand_word());
    wait_results();
  endtask

  task automatic test_random();
    int target;
    target = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) target = $urandom_range(0, STACK_DEPTH + 4);
      if (n == RANDOM_ITEMS / 2) wait_results();
      send_instr(pick_op(target), rand_word());
    end
    wait_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_stack_limits();
    test_backpressure();
    test_random();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
+incdir+rtl
rtl/sme_pkg.sv
rtl/stack_machine_executor.sv
bench/tb_top.sv
